// ===== rtl/core/rc_channel_normalize_smooth_top_assert.svh =====
// Assertion macros used by the channel normalizer checker.
`ifndef RC_CHANNEL_NORMALIZE_SMOOTH_TOP_ASSERT_SVH
`define RC_CHANNEL_NORMALIZE_SMOOTH_TOP_ASSERT_SVH
// Clocked check, masked while reset is held.
`define RCN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rcn: port check failed");
// Same form, used for value range checks on the result channel.
`define RCN_ASSERT_RANGE(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rcn: result out of range");
`endif

// ===== rtl/core/rcn_pkg.sv =====
// Shared constants and types of the channel normalizer.
package rcn_pkg;
  localparam int FRAC_BITS = 8;
  localparam int PCT_SCALE = 100 << FRAC_BITS;
  localparam int QW        = 15;  // quotient bits, holds PCT_SCALE
  localparam int PCT_W     = 16;
  localparam int UPCT_W    = 15;
  localparam int NUM_LANES = 6;

  localparam int RST_STICK_MIN = 1000;
  localparam int RST_STICK_MID = 1500;
  localparam int RST_STICK_MAX = 2000;

  localparam logic [2:0] REG_STICK_MIN   = 3'd0;
  localparam logic [2:0] REG_STICK_MID   = 3'd1;
  localparam logic [2:0] REG_STICK_MAX   = 3'd2;
  localparam logic [2:0] REG_SWITCH_LOW  = 3'd3;
  localparam logic [2:0] REG_SWITCH_MID  = 3'd4;
  localparam logic [2:0] REG_SWITCH_HIGH = 3'd5;

  typedef struct packed {
    logic start;
    logic commit;
  } lane_ctl_t;
endpackage

// ===== rtl/core/rcn_lane.sv =====
// One analog channel: clamp, ratio by restoring divider, smoothing filter.
module rcn_lane import rcn_pkg::*; #(
  parameter int RAW_BITS = 12,
  parameter bit CENTERED = 1'b1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lane_ctl_t                  ctl,
  input  logic [RAW_BITS-1:0]        raw,
  input  logic [RAW_BITS-1:0]        lim_min,
  input  logic [RAW_BITS-1:0]        lim_mid,
  input  logic [RAW_BITS-1:0]        lim_max,
  output logic                       ready,
  output logic signed [PCT_W-1:0]    y_new
);
  localparam int NW = RAW_BITS + QW;
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;

  logic [2:0]                  st_r, st_nxt;
  logic [3:0]                  cnt_r, cnt_nxt;
  logic [RAW_BITS-1:0]         d_r, span_r;
  logic                        neg_r, zero_r;
  logic [RAW_BITS:0]           rem_r;
  logic [QW-1:0]               low_r, q_r;
  logic signed [PCT_W-1:0]     y_r;

  logic [RAW_BITS-1:0]         vlo, v;
  logic signed [RAW_BITS+1:0]  vs, mins, mids, maxs, d, sp, dl;
  logic                        neg, zero;
  logic [NW-1:0]               num;
  logic [RAW_BITS:0]           trial;
  logic                        ge;
  logic signed [PCT_W-1:0]     tgt;
  logic signed [23:0]          acc;

  always_comb begin
    vlo  = (raw < lim_min) ? lim_min : raw;
    v    = (vlo > lim_max) ? lim_max : vlo;
    vs   = $signed({2'b00, v});
    mins = $signed({2'b00, lim_min});
    mids = $signed({2'b00, lim_mid});
    maxs = $signed({2'b00, lim_max});
    if (CENTERED && (vs < mids)) begin
      d   = mids - vs;
      sp  = mids - mins;
      neg = 1'b1;
    end else if (CENTERED) begin
      d   = vs - mids;
      sp  = maxs - mids;
      neg = 1'b0;
    end else begin
      d   = vs - mins;
      sp  = maxs - mins;
      neg = 1'b0;
    end
    zero = (sp <= 0) || (d <= 0);
    dl   = (d > sp) ? sp : d;
  end

  // rounding: add half the span before dividing
  assign num   = NW'(d_r) * NW'(PCT_SCALE) + NW'(span_r >> 1);
  assign trial = {rem_r[RAW_BITS-1:0], low_r[QW-1]};
  assign ge    = trial >= {1'b0, span_r};

  always_comb begin
    if (zero_r)     tgt = '0;
    else if (neg_r) tgt = -$signed({1'b0, q_r});
    else            tgt = $signed({1'b0, q_r});
    acc   = 24'(tgt) * 24'sd102 + 24'(y_r) * 24'sd154 + 24'sd128;
    y_new = acc[PCT_W+7:8];
  end

  assign ready = (st_r == ST_WAIT);

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    case (st_r)
      ST_IDLE: if (ctl.start) st_nxt = ST_MUL;
      ST_MUL: begin
        st_nxt  = ST_DIV;
        cnt_nxt = '0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(QW - 1)) st_nxt = ST_WAIT;
      end
      ST_WAIT: if (ctl.commit) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
      y_r   <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (st_r == ST_WAIT && ctl.commit) y_r <= y_new;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        d_r    <= dl[RAW_BITS-1:0];
        span_r <= sp[RAW_BITS-1:0];
        neg_r  <= neg;
        zero_r <= zero;
      end
      ST_MUL: begin
        rem_r <= {1'b0, num[NW-1:QW]};
        low_r <= num[QW-1:0];
        q_r   <= '0;
      end
      ST_DIV: begin
        rem_r <= ge ? (trial - {1'b0, span_r}) : trial;
        low_r <= {low_r[QW-2:0], 1'b0};
        q_r   <= {q_r[QW-2:0], ge};
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/core/rcn_merge.sv =====
// Merge stage: gathers lane results, decodes switches, holds the output register.
module rcn_merge import rcn_pkg::*; #(
  parameter int RAW_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    commit,
  input  logic                    out_stall,
  input  logic [PCT_W-1:0]        lane_y [NUM_LANES],
  input  logic [RAW_BITS-1:0]     sw_raw [4],
  input  logic [RAW_BITS-1:0]     lvl_low,
  input  logic [RAW_BITS-1:0]     lvl_mid,
  input  logic [RAW_BITS-1:0]     lvl_high,
  output logic                    free,
  output logic                    out_valid,
  output logic [PCT_W-1:0]        pct [NUM_LANES],
  output logic [1:0]              pos [4]
);
  logic             out_valid_r, out_valid_nxt;
  logic [PCT_W-1:0] pct_r [NUM_LANES];
  logic [1:0]       pos_r [4];
  logic [1:0]       pos_nxt [4];

  assign free = !out_valid_r || !out_stall;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (sw_raw[i] == lvl_low) pos_nxt[i] = 2'd0;
      else if (i == 2 && sw_raw[i] == lvl_mid) pos_nxt[i] = 2'd1;
      else if (sw_raw[i] == lvl_high) pos_nxt[i] = (i == 2) ? 2'd2 : 2'd1;
      else pos_nxt[i] = pos_r[i];
    end
    out_valid_nxt = commit ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) pos_r[i] <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (commit) for (int i = 0; i < 4; i++) pos_r[i] <= pos_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (commit) for (int i = 0; i < NUM_LANES; i++) pct_r[i] <= lane_y[i];
  end

  assign out_valid = out_valid_r;
  assign pct       = pct_r;
  assign pos       = pos_r;
endmodule

// ===== rtl/core/rc_channel_normalize_smooth_top.sv =====
// Receiver channel normalizer top level: config registers, lanes and merge.
// Each frame is clamped at the edge that accepts it. The result register
// then loads after a multiply step, the per-lane restoring divider (15
// quotient bits, one quotient bit per cycle) and the filter/commit step.
// All six analog lanes divide in parallel. No new frame is taken while one
// is in flight; the next frame can be taken the cycle after commit. Commit
// waits while a finished result is still stalled in the output register.
// Config writes are taken every cycle (cfg_ready is tied high) and must
// only be issued while the block is idle.
module rc_channel_normalize_smooth_top import rcn_pkg::*; #(
  parameter int RAW_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [RAW_BITS-1:0]        cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [RAW_BITS-1:0]        in_left_x_raw,
  input  logic [RAW_BITS-1:0]        in_left_y_raw,
  input  logic [RAW_BITS-1:0]        in_right_x_raw,
  input  logic [RAW_BITS-1:0]        in_right_y_raw,
  input  logic [RAW_BITS-1:0]        in_knob_a_raw,
  input  logic [RAW_BITS-1:0]        in_knob_b_raw,
  input  logic [RAW_BITS-1:0]        in_switch_a_raw,
  input  logic [RAW_BITS-1:0]        in_switch_b_raw,
  input  logic [RAW_BITS-1:0]        in_switch_c_raw,
  input  logic [RAW_BITS-1:0]        in_switch_d_raw,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [PCT_W-1:0]    out_left_x_pct,
  output logic [UPCT_W-1:0]          out_left_y_pct,
  output logic signed [PCT_W-1:0]    out_right_x_pct,
  output logic signed [PCT_W-1:0]    out_right_y_pct,
  output logic [UPCT_W-1:0]          out_knob_a_pct,
  output logic [UPCT_W-1:0]          out_knob_b_pct,
  output logic                       out_switch_a_pos,
  output logic                       out_switch_b_pos,
  output logic [1:0]                 out_switch_c_pos,
  output logic                       out_switch_d_pos
);
  logic [RAW_BITS-1:0] stick_min_r, stick_mid_r, stick_max_r;
  logic [RAW_BITS-1:0] switch_low_r, switch_mid_r, switch_high_r;
  logic                busy_r, busy_nxt;
  logic [RAW_BITS-1:0] sw_raw_r [4];
  logic [RAW_BITS-1:0] lane_raw [NUM_LANES];
  logic [PCT_W-1:0]    lane_y [NUM_LANES];
  logic [NUM_LANES-1:0] lane_rdy;
  logic [PCT_W-1:0]    pct [NUM_LANES];
  logic [1:0]          pos [4];
  logic                accept, free;
  lane_ctl_t           ctl;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy_r;
  assign accept    = in_valid && !busy_r;
  assign ctl.start  = accept;
  assign ctl.commit = busy_r && (&lane_rdy) && free;
  assign busy_nxt   = accept ? 1'b1 : (busy_r && !ctl.commit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      stick_min_r   <= RAW_BITS'(RST_STICK_MIN);
      stick_mid_r   <= RAW_BITS'(RST_STICK_MID);
      stick_max_r   <= RAW_BITS'(RST_STICK_MAX);
      switch_low_r  <= RAW_BITS'(RST_STICK_MIN);
      switch_mid_r  <= RAW_BITS'(RST_STICK_MID);
      switch_high_r <= RAW_BITS'(RST_STICK_MAX);
    end else begin
      busy_r <= busy_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_STICK_MIN:   stick_min_r   <= cfg_data;
          REG_STICK_MID:   stick_mid_r   <= cfg_data;
          REG_STICK_MAX:   stick_max_r   <= cfg_data;
          REG_SWITCH_LOW:  switch_low_r  <= cfg_data;
          REG_SWITCH_MID:  switch_mid_r  <= cfg_data;
          REG_SWITCH_HIGH: switch_high_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sw_raw_r[0] <= in_switch_a_raw;
      sw_raw_r[1] <= in_switch_b_raw;
      sw_raw_r[2] <= in_switch_c_raw;
      sw_raw_r[3] <= in_switch_d_raw;
    end
  end

  assign lane_raw[0] = in_left_x_raw;
  assign lane_raw[1] = in_left_y_raw;
  assign lane_raw[2] = in_right_x_raw;
  assign lane_raw[3] = in_right_y_raw;
  assign lane_raw[4] = in_knob_a_raw;
  assign lane_raw[5] = in_knob_b_raw;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    rcn_lane #(
      .RAW_BITS (RAW_BITS),
      .CENTERED ((g == 0) || (g == 2) || (g == 3))
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .raw     (lane_raw[g]),
      .lim_min (stick_min_r),
      .lim_mid (stick_mid_r),
      .lim_max (stick_max_r),
      .ready   (lane_rdy[g]),
      .y_new   (lane_y[g])
    );
  end

  rcn_merge #(.RAW_BITS(RAW_BITS)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (ctl.commit),
    .out_stall (out_stall),
    .lane_y    (lane_y),
    .sw_raw    (sw_raw_r),
    .lvl_low   (switch_low_r),
    .lvl_mid   (switch_mid_r),
    .lvl_high  (switch_high_r),
    .free      (free),
    .out_valid (out_valid),
    .pct       (pct),
    .pos       (pos)
  );

  assign out_left_x_pct   = pct[0];
  assign out_left_y_pct   = pct[1][UPCT_W-1:0];
  assign out_right_x_pct  = pct[2];
  assign out_right_y_pct  = pct[3];
  assign out_knob_a_pct   = pct[4][UPCT_W-1:0];
  assign out_knob_b_pct   = pct[5][UPCT_W-1:0];
  assign out_switch_a_pos = pos[0][0];
  assign out_switch_b_pos = pos[1][0];
  assign out_switch_c_pos = pos[2];
  assign out_switch_d_pos = pos[3][0];
endmodule

// ===== rtl/core/rcn_checker.sv =====
// Port-level checker for the channel normalizer, bound to the top level.
`include "rc_channel_normalize_smooth_top_assert.svh"
module rcn_checker import rcn_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [PCT_W-1:0] out_left_x_pct,
  input logic [UPCT_W-1:0]       out_left_y_pct,
  input logic [1:0]              out_switch_c_pos
);
  `RCN_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
  `RCN_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_left_x_pct))
  // an accepted frame sets busy, so two frames never enter back to back
  `RCN_ASSERT(a_in_gap, in_valid && !in_stall |=> in_stall)
  `RCN_ASSERT_RANGE(a_uni_rng, out_valid |-> out_left_y_pct <= 15'd25600)
  `RCN_ASSERT_RANGE(a_sw_c_rng, out_valid |-> out_switch_c_pos != 2'd3)
endmodule

bind rc_channel_normalize_smooth_top rcn_checker u_rcn_checker (.*);
